/* sv/pfc_pkg.sv */
// Package for the pulse frame capture block: payload and configuration types,
// capture modes, register indexes and sizing constants. No dependencies.
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int BufDepth = 4096;
  localparam int IdxW     = $clog2(BufDepth);
  localparam int CntW     = IdxW + 1;
  localparam int DurW     = 32;
  localparam int MagW     = 15;
  localparam int SampW    = MagW + 1;
  localparam int CfgW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);

  localparam logic [MagW-1:0] ClampUs = {MagW{1'b1}};

  typedef enum logic [1:0] {
    ModeWait = 2'd0,
    ModeRec  = 2'd1,
    ModeDone = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegCaptureEnable    = 3'd0,
    RegTargetSecond     = 3'd1,
    RegMinPulseUs       = 3'd2,
    RegSilenceGapUs     = 3'd3,
    RegMinFramePulses   = 3'd4,
    RegAutoAcceptPulses = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic            func;
    logic            level;
    logic [DurW-1:0] duration_us;
  } in_item_t;

  typedef struct packed {
    logic                    write_valid;
    logic                    slot;
    logic [IdxW-1:0]         write_index;
    logic signed [SampW-1:0] sample;
    logic                    frame_done;
    logic                    frame_discarded;
    logic [CntW-1:0]         frame_length;
    logic [1:0]              mode;
  } out_item_t;

  typedef struct packed {
    logic            capture_enable;
    logic            target_second;
    logic [MagW-1:0] good_min_us;
    logic [DurW-1:0] gap_over_us;
    logic [CntW-1:0] accept_min_cnt;
    logic [CntW-1:0] auto_done_cnt;
  } cfg_t;

  // Classified pulse as it waits in the queue.
  typedef struct packed {
    logic            rearm;
    logic            level;
    logic            good;
    logic            silence;
    logic [MagW-1:0] mag;
  } qent_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic not_empty;
  } qstat_t;

endpackage

/* sv/pfc_front.sv */
// Front part of the pulse frame capture block: accepts input transactions,
// clamps the duration and classifies it against the thresholds. Uses pfc_pkg.
`timescale 1ns / 1ps

module pfc_front (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pfc_pkg::in_item_t in_data_i,
  input  pfc_pkg::cfg_t    cfg_i,
  input  pfc_pkg::qstat_t  qstat_i,
  output logic             push_o,
  output pfc_pkg::qent_t   entry_o
);
  import pfc_pkg::*;

  logic            over_clamp;
  logic [MagW-1:0] mag;

  assign over_clamp = in_data_i.duration_us > DurW'(ClampUs);
  assign mag        = over_clamp ? ClampUs : in_data_i.duration_us[MagW-1:0];

  assign in_stall_o = qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

  always_comb begin
    entry_o.rearm   = in_data_i.func;
    entry_o.level   = in_data_i.level;
    entry_o.good    = mag >= cfg_i.good_min_us;
    entry_o.silence = in_data_i.duration_us > cfg_i.gap_over_us;
    entry_o.mag     = mag;
  end

endmodule

/* sv/pfc_queue.sv */
// Short queue between the front and back parts of the pulse frame capture
// block. Holds classified pulses. Uses pfc_pkg.
`timescale 1ns / 1ps

module pfc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pfc_pkg::qent_t  entry_i,
  input  logic            pop_i,
  output pfc_pkg::qent_t  head_o,
  output pfc_pkg::qstat_t qstat_o
);
  import pfc_pkg::*;

  qent_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]    count_q, count_d;

  assign head_o            = mem_q[rd_ptr_q];
  assign qstat_o.full      = count_q == (QPtrW+1)'(QDepth);
  assign qstat_o.not_empty = count_q != '0;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage, no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* sv/pfc_back.sv */
// Back part of the pulse frame capture block: runs the capture state
// machine on each queued pulse and holds the result register. Uses pfc_pkg.
`timescale 1ns / 1ps

module pfc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfc_pkg::cfg_t      cfg_i,
  input  pfc_pkg::qent_t     head_i,
  input  pfc_pkg::qstat_t    qstat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pfc_pkg::out_item_t out_data_o
);
  import pfc_pkg::*;

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] fc_q, fc_d;
  logic [CntW-1:0] gc_q, gc_d;
  logic [CntW-1:0] gc_inc;
  logic            buf_full;
  logic            out_valid_q;
  out_item_t       out_q, res_d;
  logic signed [SampW-1:0] mag_s, end_s;

  // Advance when a result register slot is free or being drained.
  assign pop_o       = qstat_i.not_empty && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign buf_full = fc_q >= CntW'(BufDepth);
  assign gc_inc   = gc_q + 1'b1;
  assign mag_s    = {1'b0, head_i.mag};
  assign end_s    = {1'b0, ClampUs};

  always_comb begin
    mode_d = mode_q;
    fc_d   = fc_q;
    gc_d   = gc_q;
    res_d  = '0;
    res_d.slot = cfg_i.target_second;
    if (head_i.rearm) begin
      mode_d = ModeWait;
      fc_d   = '0;
      gc_d   = '0;
    end else if (cfg_i.capture_enable) begin
      unique case (mode_q)
        ModeWait: begin
          if (head_i.good) begin
            res_d.write_valid = 1'b1;
            res_d.sample      = head_i.level ? mag_s : -mag_s;
            fc_d   = CntW'(1);
            gc_d   = CntW'(1);
            mode_d = ModeRec;
          end
        end
        ModeRec: begin
          if (buf_full || head_i.silence) begin
            if (gc_q >= cfg_i.accept_min_cnt) begin
              if (!buf_full) begin
                res_d.write_valid = 1'b1;
                res_d.write_index = fc_q[IdxW-1:0];
                res_d.sample      = head_i.level ? end_s : -end_s;
                fc_d = fc_q + 1'b1;
              end
              mode_d           = ModeDone;
              res_d.frame_done = 1'b1;
            end else begin
              // Drop the short frame and wait again.
              fc_d   = '0;
              gc_d   = '0;
              mode_d = ModeWait;
              res_d.frame_discarded = 1'b1;
            end
          end else begin
            res_d.write_valid = 1'b1;
            res_d.write_index = fc_q[IdxW-1:0];
            res_d.sample      = head_i.level ? mag_s : -mag_s;
            fc_d = fc_q + 1'b1;
            if (head_i.good) begin
              gc_d = gc_inc;
              if (gc_inc >= cfg_i.auto_done_cnt) begin
                mode_d           = ModeDone;
                res_d.frame_done = 1'b1;
              end
            end
          end
        end
        default: begin
          // Done holds until rearm.
        end
      endcase
    end
    res_d.frame_length = fc_d;
    res_d.mode         = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeWait;
      fc_q        <= '0;
      gc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q      <= mode_d;
        fc_q        <= fc_d;
        gc_q        <= gc_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res_d;
    end
  end

endmodule

/* sv/pulse_frame_capture.sv */
// Top level of the pulse frame capture block: configuration registers and
// the front, queue and back parts. Uses pfc_pkg, pfc_front, pfc_queue, pfc_back.
`timescale 1ns / 1ps

// Usage:
// - Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
//   demodulated pulse or rearm command. Accepted on a rising edge with valid
//   high and stall low.
// - Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
//   result transaction per input transaction, in order.
// - Configuration (cfg_we_i / cfg_index_i / cfg_wdata_i): write one register
//   per enabled edge; write only while no transaction is in flight.
// - Path: an accepted input is first stored in the front queue, then its
//   result is captured in the back result register, where it waits for the
//   receiver.
// - Throughput: one transaction per cycle while the receiver does not stall,
//   set by the update of the capture state in the back part.
// - Stall: when the receiver stalls, the result register holds and the
//   two-entry queue absorbs further input; input stall rises once it fills.
// - Reset: mode returns to waiting, frame and good counts clear, the queue
//   empties and the registers take their default values.
module pulse_frame_capture (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pfc_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pfc_pkg::out_item_t                 out_data_o,
  input  logic                               cfg_we_i,
  input  logic [pfc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pfc_pkg::CfgW-1:0]           cfg_wdata_i
);
  import pfc_pkg::*;

  cfg_t   cfg_q;
  logic   push;
  logic   pop;
  qent_t  entry;
  qent_t  head;
  qstat_t qstat;

  // Configuration registers; truncate write data to each register's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capture_enable <= 1'b0;
      cfg_q.target_second  <= 1'b0;
      cfg_q.good_min_us    <= MagW'(50);
      cfg_q.gap_over_us    <= DurW'(50000);
      cfg_q.accept_min_cnt <= CntW'(20);
      cfg_q.auto_done_cnt  <= CntW'(300);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        RegCaptureEnable:    cfg_q.capture_enable <= cfg_wdata_i[0];
        RegTargetSecond:     cfg_q.target_second  <= cfg_wdata_i[0];
        RegMinPulseUs:       cfg_q.good_min_us    <= cfg_wdata_i[MagW-1:0];
        RegSilenceGapUs:     cfg_q.gap_over_us    <= cfg_wdata_i[DurW-1:0];
        RegMinFramePulses:   cfg_q.accept_min_cnt <= cfg_wdata_i[CntW-1:0];
        RegAutoAcceptPulses: cfg_q.auto_done_cnt  <= cfg_wdata_i[CntW-1:0];
        default: begin
          // Drop writes to unmapped indexes.
        end
      endcase
    end
  end

  // Classify the pulse on entry.
  pfc_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .qstat_i    (qstat),
    .push_o     (push),
    .entry_o    (entry)
  );

  // Decouple the front from a stalled back end.
  pfc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // Run the capture state machine and register each result.
  pfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
